FILE: src/odcrf_pkg.sv
`timescale 1ns / 1ps
package odcrf_pkg;

    localparam logic [7:0] BLANK_CHAR    = 8'h20;
    localparam logic [7:0] END_CODE      = 8'hFF;
    localparam logic [7:0] QUESTION_CHAR = 8'h3F;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_FIND   = 2'd1;
    localparam logic [1:0] ACT_COMMIT = 2'd2;
    localparam logic [1:0] ACT_INVAL  = 2'd3;

    typedef struct packed {
        logic       found;
        logic [8:0] address;
        logic [7:0] char_code;
        logic       last;
    } result_t;

    function automatic logic [7:0] map_char(input logic [7:0] raw);
        return (raw == END_CODE) ? QUESTION_CHAR : raw;
    endfunction

endpackage

FILE: src/odcrf_ram.sv
`timescale 1ns / 1ps
module odcrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 480
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_array[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/osd_dirty_cell_run_finder.sv
`timescale 1ns / 1ps
// channel | signals                     | contents
// --------+-----------------------------+-----------------------------------------------
// input   | s_tvalid s_tready s_tuser   | tuser: action; tdata: cell_index, cell_char
//         | s_tdata                     |
// result  | m_tvalid m_tready m_tuser   | tuser: run_found; tlast: run_last;
//         | m_tdata m_tlast             | tdata: run_address, run_char, pending_count
// config  | cfg_wen cfg_wdata           | ntsc_mode
//
// after reset a clearing pass over all SCREEN_COLUMNS*SCREEN_ROWS cells fills the screen
// memories; no item is taken until it ends. write: read the cell, then update it. commit:
// read and update each captured cell, then respond. invalidate: clear every screen cell's
// shown flag, then respond. find: read cells from screen start to run end (one read port),
// then read and emit each captured cell; with nothing pending, the visible cells are read.
// results wait in an output register while m_tready is low; counts kept per region.
module osd_dirty_cell_run_finder #(
    parameter int SCREEN_COLUMNS = 30,
    parameter int SCREEN_ROWS    = 16,
    parameter int NTSC_ROWS      = 13,
    parameter int MAX_RUN        = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,  // action
    input  logic [23:0] s_tdata,  // cell_index[8:0], cell_char[16:9], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [0:0]  m_tuser,  // run_found
    output logic [31:0] m_tdata,  // run_address[8:0], run_char[16:9], pending_count[25:17]
    output logic        m_tlast
);

    localparam int CELL_TOTAL = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int NTSC_LIMIT = SCREEN_COLUMNS *
                                ((NTSC_ROWS < SCREEN_ROWS) ? NTSC_ROWS : SCREEN_ROWS);
    localparam int AW = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
    localparam int CW = $clog2(CELL_TOTAL + 1);
    localparam int RW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int LW = $clog2(MAX_RUN + 1);

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_WR_RD   = 4'd2;
    localparam logic [3:0] ST_WR_UPD  = 4'd3;
    localparam logic [3:0] ST_SCAN    = 4'd4;
    localparam logic [3:0] ST_EMIT_RD = 4'd5;
    localparam logic [3:0] ST_EMIT_LD = 4'd6;
    localparam logic [3:0] ST_CM_RD   = 4'd7;
    localparam logic [3:0] ST_CM_UPD  = 4'd8;
    localparam logic [3:0] ST_INV     = 4'd9;
    localparam logic [3:0] ST_RESP    = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic          ntsc_reg, ntsc_next;
    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] scan_addr_reg, scan_addr_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [LW-1:0] scan_len_reg, scan_len_next;
    logic [AW-1:0] cap_start_reg, cap_start_next;
    logic [LW-1:0] cap_len_reg, cap_len_next;
    logic [LW-1:0] item_idx_reg, item_idx_next;
    logic [8:0]    wr_idx_reg, wr_idx_next;
    logic [7:0]    wr_char_reg, wr_char_next;
    logic          m_tvalid_reg, m_tvalid_next;
    odcrf_pkg::result_t out_reg, out_next;
    logic [8:0]    out_pend_reg, out_pend_next;

    logic          des_we;
    logic [AW-1:0] des_waddr;
    logic [7:0]    des_wdata;
    logic          sh_we;
    logic [AW-1:0] sh_waddr;
    logic [8:0]    sh_wdata;
    logic [AW-1:0] main_raddr;
    logic [7:0]    des_rdata;
    logic [8:0]    sh_rdata;
    logic          cap_we;
    logic [RW-1:0] cap_waddr;
    logic [7:0]    cap_wdata;
    logic [RW-1:0] cap_raddr;
    logic [7:0]    cap_rdata;

    logic          accept;
    logic          out_free;
    logic [CW-1:0] limit;
    logic [CW-1:0] pending;
    logic [7:0]    des_mapped;
    logic          cell_dirty;
    logic [AW-1:0] cm_addr;
    logic          wr_in_range;
    logic          capture;
    logic          stop_now;
    logic          rd_issue;
    logic [LW-1:0] len_new;
    logic          item_last;
    logic          upd_en;
    logic [AW-1:0] upd_addr;
    logic          upd_before;
    logic          upd_after;

    odcrf_ram #(.WIDTH(8), .DEPTH(CELL_TOTAL)) u_desired_ram (
        .aclk    (aclk),
        .wr_en   (des_we),
        .wr_addr (des_waddr),
        .wr_data (des_wdata),
        .rd_addr (main_raddr),
        .rd_data (des_rdata)
    );

    odcrf_ram #(.WIDTH(9), .DEPTH(CELL_TOTAL)) u_shadow_ram (
        .aclk    (aclk),
        .wr_en   (sh_we),
        .wr_addr (sh_waddr),
        .wr_data (sh_wdata),
        .rd_addr (main_raddr),
        .rd_data (sh_rdata)
    );

    odcrf_ram #(.WIDTH(8), .DEPTH(MAX_RUN)) u_capture_ram (
        .aclk    (aclk),
        .wr_en   (cap_we),
        .wr_addr (cap_waddr),
        .wr_data (cap_wdata),
        .rd_addr (cap_raddr),
        .rd_data (cap_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign limit    = ntsc_reg ? CW'(NTSC_LIMIT) : CW'(CELL_TOTAL);
    assign pending  = ntsc_reg ? cnt_a_reg : CW'(cnt_a_reg + cnt_b_reg);

    assign des_mapped  = odcrf_pkg::map_char(des_rdata);
    assign cell_dirty  = !sh_rdata[8] || (sh_rdata[7:0] != des_mapped);
    assign cm_addr     = AW'(32'(cap_start_reg) + 32'(item_idx_reg));
    assign wr_in_range = 32'(wr_idx_reg) < 32'(CELL_TOTAL);
    assign item_last   = (item_idx_reg + LW'(1)) == cap_len_reg;

    // scan pipeline: a read issued per cycle, evaluated in the cycle after it is issued
    assign capture  = (state_reg == ST_SCAN) && rd_vld_reg && cell_dirty;
    assign stop_now = (state_reg == ST_SCAN) && rd_vld_reg &&
                      ((cell_dirty && (32'(scan_len_reg) + 1 == MAX_RUN)) ||
                       (!cell_dirty && (scan_len_reg != '0)));
    assign rd_issue = (state_reg == ST_SCAN) && (scan_addr_reg < limit) && !stop_now;
    assign len_new  = capture ? LW'(scan_len_reg + LW'(1)) : scan_len_reg;

    always_comb begin
        case (state_reg)
            ST_WR_RD, ST_WR_UPD: main_raddr = AW'(wr_idx_reg);
            ST_SCAN:             main_raddr = scan_addr_reg[AW-1:0];
            default:             main_raddr = cm_addr;
        endcase
    end

    assign cap_raddr = item_idx_reg[RW-1:0];
    assign cap_we    = capture;
    assign cap_waddr = scan_len_reg[RW-1:0];
    assign cap_wdata = des_mapped;

    always_comb begin
        des_we    = 1'b0;
        des_waddr = scan_addr_reg[AW-1:0];
        des_wdata = odcrf_pkg::BLANK_CHAR;
        sh_we     = 1'b0;
        sh_waddr  = scan_addr_reg[AW-1:0];
        sh_wdata  = '0;
        case (state_reg)
            ST_CLEAR: begin
                des_we = 1'b1;
                sh_we  = 1'b1;
            end
            ST_INV: begin
                sh_we = 1'b1;
            end
            ST_WR_UPD: begin
                des_we    = wr_in_range;
                des_waddr = AW'(wr_idx_reg);
                des_wdata = wr_char_reg;
            end
            ST_CM_UPD: begin
                sh_we    = 1'b1;
                sh_waddr = cm_addr;
                sh_wdata = {1'b1, cap_rdata};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        upd_en     = 1'b0;
        upd_addr   = cm_addr;
        upd_before = cell_dirty;
        upd_after  = cap_rdata != des_mapped;
        if (state_reg == ST_WR_UPD) begin
            upd_en    = wr_in_range;
            upd_addr  = AW'(wr_idx_reg);
            upd_after = !sh_rdata[8] ||
                        (sh_rdata[7:0] != odcrf_pkg::map_char(wr_char_reg));
        end else if (state_reg == ST_CM_UPD) begin
            upd_en = 1'b1;
        end
    end

    always_comb begin
        state_next     = state_reg;
        ntsc_next      = cfg_wen ? cfg_wdata : ntsc_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        scan_addr_next = scan_addr_reg;
        rd_vld_next    = rd_issue;
        rd_addr_next   = scan_addr_reg[AW-1:0];
        scan_len_next  = scan_len_reg;
        cap_start_next = cap_start_reg;
        cap_len_next   = cap_len_reg;
        item_idx_next  = item_idx_reg;
        wr_idx_next    = wr_idx_reg;
        wr_char_next   = wr_char_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_next       = out_reg;
        out_pend_next  = out_pend_reg;

        if (upd_en && (upd_before != upd_after)) begin
            if (32'(upd_addr) < NTSC_LIMIT) begin
                cnt_a_next = upd_after ? CW'(cnt_a_reg + CW'(1)) : CW'(cnt_a_reg - CW'(1));
            end else begin
                cnt_b_next = upd_after ? CW'(cnt_b_reg + CW'(1)) : CW'(cnt_b_reg - CW'(1));
            end
        end

        unique case (state_reg)
            ST_CLEAR: begin
                scan_addr_next = CW'(scan_addr_reg + CW'(1));
                if (scan_addr_reg == CW'(CELL_TOTAL - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    wr_idx_next    = s_tdata[8:0];
                    wr_char_next   = s_tdata[16:9];
                    scan_addr_next = '0;
                    scan_len_next  = '0;
                    item_idx_next  = '0;
                    unique case (s_tuser)
                        odcrf_pkg::ACT_WRITE:  state_next = ST_WR_RD;
                        odcrf_pkg::ACT_FIND:   state_next = ST_SCAN;
                        odcrf_pkg::ACT_COMMIT: begin
                            state_next = (cap_len_reg == '0) ? ST_RESP : ST_CM_RD;
                        end
                        odcrf_pkg::ACT_INVAL:  state_next = ST_INV;
                        default:               state_next = ST_RESP;
                    endcase
                end
            end
            ST_WR_RD: begin
                state_next = ST_WR_UPD;
            end
            ST_WR_UPD: begin
                state_next = ST_RESP;
            end
            ST_SCAN: begin
                if (rd_issue) begin
                    scan_addr_next = CW'(scan_addr_reg + CW'(1));
                end
                scan_len_next = len_new;
                if (capture && (scan_len_reg == '0)) begin
                    cap_start_next = rd_addr_reg;
                end
                if (stop_now || (!rd_vld_reg && (scan_addr_reg >= limit))) begin
                    item_idx_next = '0;
                    if (len_new != '0) begin
                        cap_len_next = len_new;
                        state_next   = ST_EMIT_RD;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    m_tvalid_next     = 1'b1;
                    out_next.found    = 1'b1;
                    out_next.address  = 9'(32'(cap_start_reg) + 32'(item_idx_reg));
                    out_next.char_code = cap_rdata;
                    out_next.last     = item_last;
                    out_pend_next     = 9'(pending);
                    item_idx_next     = LW'(item_idx_reg + LW'(1));
                    state_next        = item_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_CM_RD: begin
                state_next = ST_CM_UPD;
            end
            ST_CM_UPD: begin
                item_idx_next = LW'(item_idx_reg + LW'(1));
                state_next    = item_last ? ST_RESP : ST_CM_RD;
            end
            ST_INV: begin
                scan_addr_next = CW'(scan_addr_reg + CW'(1));
                if (scan_addr_reg == CW'(CELL_TOTAL - 1)) begin
                    cnt_a_next = CW'(NTSC_LIMIT);
                    cnt_b_next = CW'(CELL_TOTAL - NTSC_LIMIT);
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next      = 1'b1;
                    out_next.found     = 1'b0;
                    out_next.address   = '0;
                    out_next.char_code = '0;
                    out_next.last      = 1'b1;
                    out_pend_next      = 9'(pending);
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            ntsc_reg      <= 1'b0;
            cnt_a_reg     <= CW'(NTSC_LIMIT);
            cnt_b_reg     <= CW'(CELL_TOTAL - NTSC_LIMIT);
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            scan_len_reg  <= '0;
            cap_start_reg <= '0;
            cap_len_reg   <= '0;
            item_idx_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ntsc_reg      <= ntsc_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            scan_addr_reg <= scan_addr_next;
            rd_vld_reg    <= rd_vld_next;
            scan_len_reg  <= scan_len_next;
            cap_start_reg <= cap_start_next;
            cap_len_reg   <= cap_len_next;
            item_idx_reg  <= item_idx_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg  <= rd_addr_next;
        wr_idx_reg   <= wr_idx_next;
        wr_char_reg  <= wr_char_next;
        out_reg      <= out_next;
        out_pend_reg <= out_pend_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.found;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {6'b0, out_pend_reg, out_reg.char_code, out_reg.address};

endmodule
